@@ rtl/core/hkrb_pkg.sv @@
// Shared types and constants for the HID boot keyboard report builder.
// No dependencies; used by every module under rtl/core.
package hkrb_pkg;

    localparam int SlotCount = 6;
    localparam int KeyWidth  = 8;

    localparam logic [1:0] CMD_PRESS       = 2'd0;
    localparam logic [1:0] CMD_RELEASE     = 2'd1;
    localparam logic [1:0] CMD_RELEASE_ALL = 2'd2;

    // upper five bits of a modifier usage code (0xE0..0xE7)
    localparam logic [4:0] MOD_PREFIX = 5'b11100;

    typedef logic [KeyWidth-1:0] key_t;

    // decoded operation, one word per accepted input
    typedef struct packed {
        logic update;      // word accepted this cycle
        logic press;       // non-modifier press
        logic release_key; // non-modifier release
        logic clear_all;   // release all
    } slot_ctrl_t;

    // carried left to right along the slot cells
    typedef struct packed {
        logic match_seen;  // an earlier slot holds the key
        logic zero_seen;   // an earlier slot is empty
    } slot_chain_t;

endpackage

@@ rtl/core/hkrb_slot_cell.sv @@
// One key slot of the report: holds a keycode, compares it with the
// incoming key and shifts from its right neighbor on release. Uses hkrb_pkg.
module hkrb_slot_cell (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  hkrb_pkg::slot_ctrl_t ctrl,
    input  hkrb_pkg::key_t       key_code,
    input  logic                 any_match,
    input  hkrb_pkg::key_t       right_value,
    input  hkrb_pkg::slot_chain_t chain_in,
    output hkrb_pkg::slot_chain_t chain_out,
    output hkrb_pkg::key_t       slot_value
);
    import hkrb_pkg::*;

    key_t slot_reg;
    key_t slot_next;
    logic hit;
    logic empty;

    assign hit   = (slot_reg == key_code);
    assign empty = (slot_reg == '0);

    assign chain_out.match_seen = chain_in.match_seen | hit;
    assign chain_out.zero_seen  = chain_in.zero_seen  | empty;

    always_comb begin
        slot_next = slot_reg;
        priority if (ctrl.clear_all) begin
            slot_next = '0;
        end else if (ctrl.press) begin
            // first empty slot takes the key unless it is already held
            if (empty && !chain_in.zero_seen && !any_match) begin
                slot_next = key_code;
            end
        end else if (ctrl.release_key) begin
            // first hit and everything after it move down one place
            if (hit || chain_in.match_seen) begin
                slot_next = right_value;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg <= '0;
        end else if (ctrl.update) begin
            slot_reg <= slot_next;
        end
    end

    assign slot_value = slot_reg;

endmodule

@@ rtl/core/hkrb_modifier.sv @@
// Modifier byte of the report: sets or clears one bit per modifier key, and
// clears all bits on release all. Uses hkrb_pkg.
module hkrb_modifier (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 update,
    input  logic [1:0]           command,
    input  hkrb_pkg::key_t       key_code,
    output logic                 is_modifier,
    output hkrb_pkg::key_t       modifier_bits
);
    import hkrb_pkg::*;

    key_t mod_reg;
    key_t mod_next;
    key_t bit_mask;

    assign is_modifier = (key_code[7:3] == MOD_PREFIX);
    assign bit_mask    = key_t'(1) << key_code[2:0];

    always_comb begin
        mod_next = mod_reg;
        unique case (command)
            CMD_PRESS: begin
                if (is_modifier) mod_next = mod_reg | bit_mask;
            end
            CMD_RELEASE: begin
                if (is_modifier) mod_next = mod_reg & ~bit_mask;
            end
            CMD_RELEASE_ALL: begin
                mod_next = '0;
            end
            default: begin
                mod_next = mod_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mod_reg <= '0;
        end else if (update) begin
            mod_reg <= mod_next;
        end
    end

    assign modifier_bits = mod_reg;

endmodule

@@ rtl/core/hid_keyboard_report_builder.sv @@
// Top level of the HID boot keyboard report builder (6-key rollover).
// Depends on hkrb_pkg, hkrb_slot_cell and hkrb_modifier.
//
//  channel | direction | ports                                   | word
//  --------+-----------+-----------------------------------------+---------------------
//  s_      | in        | s_valid s_ready s_command s_key_code    | one command
//  m_      | out       | m_valid m_ready m_accepted m_modifier_* | flag + full report
//
// Cycles: one command per clock when not stalled. A word is decoded, compared
// against the six slot cells and written into the report registers in the cycle
// it is taken; its result is presented the next cycle. The slot chain (compare,
// first-free pick, shift) is the one combinational path that sets that figure.
// Reset: aresetn low clears the modifier byte, all six slots and m_valid.
// Stalls: the report registers are the result word, so while m_valid is high
// and m_ready low no new command is taken; taking a result and a new command
// in the same cycle keeps the rate at one per clock.
module hid_keyboard_report_builder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_command,
    input  logic [7:0] s_key_code,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_accepted,
    output logic [7:0] m_modifier_bits,
    output logic [7:0] m_slot_zero,
    output logic [7:0] m_slot_one,
    output logic [7:0] m_slot_two,
    output logic [7:0] m_slot_three,
    output logic [7:0] m_slot_four,
    output logic [7:0] m_slot_five
);
    import hkrb_pkg::*;

    logic        take;
    logic        is_modifier;
    slot_ctrl_t  ctrl;
    slot_chain_t chain [SlotCount+1];
    key_t        slot_q [SlotCount];
    key_t        right_q [SlotCount];
    logic        any_match;
    logic        any_zero;
    logic        ok;

    logic        m_valid_reg;
    logic        accepted_reg;

    // a word moves in whenever the result register is free or being drained
    assign s_ready = !m_valid_reg || m_ready;
    assign take    = s_valid && s_ready;

    // decode the command; modifier keys never reach the slot cells
    assign ctrl.update      = take;
    assign ctrl.press       = (s_command == CMD_PRESS)   && !is_modifier;
    assign ctrl.release_key = (s_command == CMD_RELEASE) && !is_modifier;
    assign ctrl.clear_all   = (s_command == CMD_RELEASE_ALL);

    hkrb_modifier u_modifier (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .update        (take),
        .command       (s_command),
        .key_code      (s_key_code),
        .is_modifier   (is_modifier),
        .modifier_bits (m_modifier_bits)
    );

    // chain head: nothing seen to the left of slot zero
    assign chain[0] = '0;

    // the match total feeds back to every cell; the zero total feeds the success flag
    assign any_match = chain[SlotCount].match_seen;
    assign any_zero  = chain[SlotCount].zero_seen;

    genvar gi;
    generate
        for (gi = 0; gi < SlotCount; gi++) begin : g_slot
            // last slot is refilled with zero on a shift
            if (gi == SlotCount - 1) begin : g_last
                assign right_q[gi] = '0;
            end else begin : g_mid
                assign right_q[gi] = slot_q[gi+1];
            end

            hkrb_slot_cell u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .ctrl        (ctrl),
                .key_code    (s_key_code),
                .any_match   (any_match),
                .right_value (right_q[gi]),
                .chain_in    (chain[gi]),
                .chain_out   (chain[gi+1]),
                .slot_value  (slot_q[gi])
            );
        end
    endgenerate

    // success flag; the unused command code reports failure
    always_comb begin
        ok = 1'b0;
        unique case (s_command)
            CMD_PRESS:       ok = is_modifier || any_match || any_zero;
            CMD_RELEASE:     ok = is_modifier || any_match;
            CMD_RELEASE_ALL: ok = 1'b1;
            default:         ok = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (take) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            accepted_reg <= ok;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_accepted   = accepted_reg;
    assign m_slot_zero  = slot_q[0];
    assign m_slot_one   = slot_q[1];
    assign m_slot_two   = slot_q[2];
    assign m_slot_three = slot_q[3];
    assign m_slot_four  = slot_q[4];
    assign m_slot_five  = slot_q[5];

    // held result blocks new commands, so the report cannot move under it
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("input taken while result stalled");

    // keys stay packed toward slot zero: an empty slot has only empty slots after it
    a_slots_packed: assert property (@(posedge aclk) disable iff (!aresetn)
        ((slot_q[0] != 8'd0) || (slot_q[1] == 8'd0)) &&
        ((slot_q[1] != 8'd0) || (slot_q[2] == 8'd0)) &&
        ((slot_q[2] != 8'd0) || (slot_q[3] == 8'd0)) &&
        ((slot_q[3] != 8'd0) || (slot_q[4] == 8'd0)) &&
        ((slot_q[4] != 8'd0) || (slot_q[5] == 8'd0)))
        else $error("key slots not packed");

    // release all leaves an empty, successful report
    a_release_all_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && (s_command == CMD_RELEASE_ALL)) |=>
        (m_accepted && (m_modifier_bits == 8'd0) && (slot_q[0] == 8'd0)))
        else $error("release all left state behind");

    // a successful key release always frees the last slot
    a_release_frees_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && ctrl.release_key && any_match) |=> (slot_q[SlotCount-1] == 8'd0))
        else $error("release did not zero the last slot");

endmodule
